// ===== src/bdpwt_pkg.sv =====
// Shared types, constants and helpers of the bus decoder with page write tracking.
`default_nettype none

package bdpwt_pkg;

  // Default sizes of the memories.
  localparam int unsigned RamBytesDef  = 65536;
  localparam int unsigned RomBytesDef  = 65536;
  localparam int unsigned PageBytesDef = 4096;

  // Field widths.
  localparam int unsigned KindW     = 3;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned LineW     = 6;
  localparam int unsigned TickInW   = 32;
  localparam int unsigned TickW     = 64;
  localparam int unsigned GenW      = 32;
  localparam int unsigned RamSizeW  = 17;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned IrqW      = 32;

  // Input and output packing on the stream buses.
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 88;

  // Register offsets of the second register of a peripheral pair.
  localparam logic [AddrW-1:0] PairOffset = 32'd4;

  // Reset values of the configuration registers.
  localparam logic [RamSizeW-1:0] RamSizeRst    = 17'd65536;
  localparam logic [AddrW-1:0]    RamBaseRst    = 32'h0000_0000;
  localparam logic [AddrW-1:0]    RomBaseRst    = 32'h00F8_0000;
  localparam logic [AddrW-1:0]    SerialBaseRst = 32'h00E0_0000;
  localparam logic [AddrW-1:0]    TimerBaseRst  = 32'h00E0_1000;
  localparam logic [AddrW-1:0]    IrqBaseRst    = 32'h00E0_2000;

  // Value returned by a read of the serial status register.
  localparam logic [ByteW-1:0] SerialReady = 8'd1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAM_SIZE    = 3'd0,
    CFG_RAM_BASE    = 3'd1,
    CFG_ROM_BASE    = 3'd2,
    CFG_SERIAL_BASE = 3'd3,
    CFG_TIMER_BASE  = 3'd4,
    CFG_IRQ_BASE    = 3'd5
  } cfg_idx_e;

  // Request kinds.
  typedef enum logic [KindW-1:0] {
    KIND_READ      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_IRQ_RAISE = 3'd2,
    KIND_IRQ_CLEAR = 3'd3,
    KIND_TICK      = 3'd4,
    KIND_ROM_LOAD  = 3'd5
  } kind_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Address decode results, taken when a request is accepted.
  typedef struct packed {
    logic in_ram;
    logic in_rom;
    logic ser_data;
    logic ser_stat;
    logic timer;
    logic irq_pend;
    logic irq_clr;
    logic rom_ld_ok;
  } decode_t;

  // Generation counters step by one and skip zero on wrap.
  function automatic logic [GenW-1:0] gen_bump(input logic [GenW-1:0] g);
    logic [GenW-1:0] n;
    n = g + GenW'(1);
    return (n == '0) ? GenW'(1) : n;
  endfunction

endpackage

`default_nettype wire

// ===== src/bus_decoder_with_page_write_tracking.sv =====
// Top level of the byte-wide system bus decoder with RAM page write tracking.
//
// Requests arrive on the s_axis channel: tuser carries the request kind (read,
// write, raise irq, clear irq, tick or ROM load) and tdata the address, write
// byte, irq line and tick count. Every request gives exactly one result on the
// m_axis channel, in order: status, read byte, serial byte, and the write
// generations of the addressed RAM page and of the whole machine.
// The configuration port writes the RAM size and the base addresses; the user
// must write it only while no request is in flight, which the block does not enforce.
// RAM, ROM and the page generation table live in synchronous memories that are
// read at the edge which accepts a request. In the execute step that follows, the
// result is formed and the modified entry is written back, and the result enters
// the output register at the edge that ends that step. A new request is not
// accepted until the previous one has left its execute step, as the memories
// take a read-then-write-back pass for each request.
// The output register lets a new request be accepted while the previous result
// still waits; if the receiver stalls, the request being processed holds in
// its execute step until the output register frees.
// After reset a clearing pass zeroes all three memories, one entry of each per cycle,
// and no request is accepted until it ends. PAGE_BYTES must be a power of two.
`default_nettype none

module bus_decoder_with_page_write_tracking
  import bdpwt_pkg::*;
#(
  parameter int unsigned RAM_DEPTH  = RamBytesDef,
  parameter int unsigned ROM_DEPTH  = RomBytesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Request channel.
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // tdata: addr[31:0], write_data[39:32], line[45:40], tick_count[77:46], zeros
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: kind[2:0]
  input  wire logic [KindW-1:0]    s_axis_tuser_i,
  // Result channel.
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tdata: ok[0], read_data[8:1], serial_valid[9], serial_byte[17:10],
  //        page_valid[18], page_generation[50:19], global_generation[82:51], zeros
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  // Configuration write port.
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PageCount = (RAM_DEPTH + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int unsigned RamAw     = $clog2(RAM_DEPTH);
  localparam int unsigned RomAw     = $clog2(ROM_DEPTH);
  localparam int unsigned PageShift = $clog2(PAGE_BYTES);
  localparam int unsigned PageAw    = (PageCount > 1) ? $clog2(PageCount) : 1;
  localparam int unsigned ClrDepth0 = (RAM_DEPTH > ROM_DEPTH) ? RAM_DEPTH : ROM_DEPTH;
  localparam int unsigned ClrDepth  = (ClrDepth0 > PageCount) ? ClrDepth0 : PageCount;
  localparam int unsigned ClrW      = $clog2(ClrDepth + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [RamSizeW-1:0] ram_len_q;
  logic [AddrW-1:0]    ram_start_q, rom_start_q, serial_base_q, timer_base_q, irq_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_len_q     <= RamSizeRst;
      ram_start_q   <= RamBaseRst;
      rom_start_q   <= RomBaseRst;
      serial_base_q <= SerialBaseRst;
      timer_base_q  <= TimerBaseRst;
      irq_base_q    <= IrqBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RAM_SIZE:    ram_len_q     <= cfg_data_i[RamSizeW-1:0];
        CFG_RAM_BASE:    ram_start_q   <= cfg_data_i;
        CFG_ROM_BASE:    rom_start_q   <= cfg_data_i;
        CFG_SERIAL_BASE: serial_base_q <= cfg_data_i;
        CFG_TIMER_BASE:  timer_base_q  <= cfg_data_i;
        CFG_IRQ_BASE:    irq_base_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   out_free, in_fire, exec_en, clr_active, clr_last;
  logic   out_valid_q;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last)        state_d = ST_IDLE;
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_EXEC;
      ST_EXEC:  if (out_free)        state_d = ST_IDLE;
      default:                       state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    exec_en         = 1'b0;
    clr_active      = 1'b0;
    unique case (state_q)
      ST_CLEAR: clr_active      = 1'b1;
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_EXEC:  exec_en         = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // The clearing pass walks every entry index once after reset.
  logic [ClrW-1:0] clr_cnt_q;

  assign clr_last = (clr_cnt_q == ClrW'(ClrDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_active && !clr_last) begin
      clr_cnt_q <= clr_cnt_q + ClrW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Address decode in the accept cycle.
  // ---------------------------------------------------------------------------
  logic [KindW-1:0]   in_kind;
  logic [AddrW-1:0]   in_addr, ram_off, rom_off, ram_used;
  logic [ByteW-1:0]   in_wdata;
  logic [LineW-1:0]   in_line;
  logic [TickInW-1:0] in_ticks;
  decode_t            dec;

  assign in_kind  = s_axis_tuser_i;
  assign in_addr  = s_axis_tdata_i[31:0];
  assign in_wdata = s_axis_tdata_i[39:32];
  assign in_line  = s_axis_tdata_i[45:40];
  assign in_ticks = s_axis_tdata_i[77:46];

  // RAM in use is the configured size, capped at the RAM that is fitted.
  assign ram_used = ({15'd0, ram_len_q} > AddrW'(RAM_DEPTH)) ? AddrW'(RAM_DEPTH)
                                                            : {15'd0, ram_len_q};
  assign ram_off  = in_addr - ram_start_q;
  assign rom_off  = in_addr - rom_start_q;

  always_comb begin
    dec.in_ram    = (in_addr >= ram_start_q) && (ram_off < ram_used);
    dec.in_rom    = (in_addr >= rom_start_q) && (rom_off < AddrW'(ROM_DEPTH));
    dec.ser_data  = (in_addr == serial_base_q);
    dec.ser_stat  = (in_addr == serial_base_q + PairOffset);
    dec.timer     = (in_addr == timer_base_q);
    dec.irq_pend  = (in_addr == irq_base_q);
    dec.irq_clr   = (in_addr == irq_base_q + PairOffset);
    dec.rom_ld_ok = (in_addr < AddrW'(ROM_DEPTH));
  end

  // Request held for its execute step.
  logic [KindW-1:0]   kind_q;
  logic [ByteW-1:0]   wdata_q;
  logic [LineW-1:0]   line_q;
  logic [TickInW-1:0] ticks_q;
  decode_t            dec_q;
  logic [RamAw-1:0]   ram_idx_q;
  logic [RomAw-1:0]   rom_ld_idx_q;
  logic [PageAw-1:0]  page_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q       <= in_kind;
      wdata_q      <= in_wdata;
      line_q       <= in_line;
      ticks_q      <= in_ticks;
      dec_q        <= dec;
      ram_idx_q    <= ram_off[RamAw-1:0];
      rom_ld_idx_q <= in_addr[RomAw-1:0];
      page_idx_q   <= ram_off[PageShift +: PageAw];
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: read when a request is accepted, written back in its execute
  // step or by the clearing pass. Only one request is in flight, so a write
  // back never overlaps a read of the same entry.
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] ram_mem [RAM_DEPTH];
  logic [ByteW-1:0] rom_mem [ROM_DEPTH];
  logic [GenW-1:0]  page_mem [PageCount];

  logic [ByteW-1:0] ram_rdata_q, rom_rdata_q;
  logic [GenW-1:0]  page_rdata_q;

  logic             ram_we, rom_we, page_we;
  logic [RamAw-1:0] ram_waddr;
  logic [RomAw-1:0] rom_waddr;
  logic [PageAw-1:0] page_waddr;
  logic [ByteW-1:0] ram_wdata, rom_wdata;
  logic [GenW-1:0]  page_wdata;

  // Results of the execute step that feed the write ports.
  logic             ex_ram_we, ex_rom_we;
  logic [GenW-1:0]  page_gen_new;

  always_comb begin
    if (clr_active) begin
      ram_we     = (clr_cnt_q < ClrW'(RAM_DEPTH));
      rom_we     = (clr_cnt_q < ClrW'(ROM_DEPTH));
      page_we    = (clr_cnt_q < ClrW'(PageCount));
      ram_waddr  = clr_cnt_q[RamAw-1:0];
      rom_waddr  = clr_cnt_q[RomAw-1:0];
      page_waddr = clr_cnt_q[PageAw-1:0];
      ram_wdata  = '0;
      rom_wdata  = '0;
      page_wdata = '0;
    end else begin
      ram_we     = ex_ram_we;
      rom_we     = ex_rom_we;
      page_we    = ex_ram_we;
      ram_waddr  = ram_idx_q;
      rom_waddr  = rom_ld_idx_q;
      page_waddr = page_idx_q;
      ram_wdata  = wdata_q;
      rom_wdata  = wdata_q;
      page_wdata = page_gen_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (in_fire) begin
      ram_rdata_q <= ram_mem[ram_off[RamAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[rom_waddr] <= rom_wdata;
    end
    if (in_fire) begin
      rom_rdata_q <= rom_mem[rom_off[RomAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
    if (in_fire) begin
      page_rdata_q <= page_mem[ram_off[PageShift +: PageAw]];
    end
  end

  // ---------------------------------------------------------------------------
  // Execute step: form the result and the state updates.
  // ---------------------------------------------------------------------------
  logic [GenW-1:0]  gen_q;
  logic [TickW-1:0] tick_q;
  logic [IrqW-1:0]  irq_q;

  logic             r_ok, r_sv, r_pv, gen_inc, tick_add, irq_upd;
  logic [ByteW-1:0] r_rd, r_sb;
  logic [GenW-1:0]  r_pg, gen_next;
  logic [IrqW-1:0]  irq_next, line_mask;

  assign page_gen_new = gen_bump(page_rdata_q);
  assign line_mask    = IrqW'(1) << line_q[4:0];

  always_comb begin
    r_ok      = 1'b0;
    r_rd      = '0;
    r_sv      = 1'b0;
    r_sb      = '0;
    ex_ram_we = 1'b0;
    ex_rom_we = 1'b0;
    gen_inc   = 1'b0;
    tick_add  = 1'b0;
    irq_upd   = 1'b0;
    irq_next  = irq_q;
    unique case (kind_q) inside
      KIND_READ: begin
        r_ok = 1'b1;
        if (dec_q.in_ram) begin
          r_rd = ram_rdata_q;
        end else if (dec_q.in_rom) begin
          r_rd = rom_rdata_q;
        end else if (dec_q.ser_data) begin
          r_rd = '0;
        end else if (dec_q.ser_stat) begin
          r_rd = SerialReady;
        end else if (dec_q.timer) begin
          r_rd = tick_q[ByteW-1:0];
        end else if (dec_q.irq_pend) begin
          r_rd = irq_q[ByteW-1:0];
        end else begin
          r_ok = 1'b0;
        end
      end
      KIND_WRITE: begin
        if (dec_q.in_ram) begin
          r_ok      = 1'b1;
          ex_ram_we = exec_en;
          gen_inc   = exec_en;
        end else if (dec_q.in_rom) begin
          r_ok = 1'b0;
        end else if (dec_q.ser_data) begin
          r_ok = 1'b1;
          r_sv = 1'b1;
          r_sb = wdata_q;
        end else if (dec_q.irq_clr) begin
          r_ok     = 1'b1;
          irq_upd  = exec_en;
          irq_next = irq_q & ~{{(IrqW - ByteW){1'b0}}, wdata_q};
        end
      end
      KIND_IRQ_RAISE, KIND_IRQ_CLEAR: begin
        // Lines 32 and above name no interrupt and are ignored.
        if (!line_q[LineW-1]) begin
          r_ok     = 1'b1;
          irq_upd  = exec_en;
          irq_next = (kind_q == KIND_IRQ_RAISE) ? (irq_q | line_mask)
                                                : (irq_q & ~line_mask);
        end
      end
      KIND_TICK: begin
        r_ok     = 1'b1;
        tick_add = exec_en;
      end
      KIND_ROM_LOAD: begin
        if (dec_q.rom_ld_ok) begin
          r_ok      = 1'b1;
          ex_rom_we = exec_en;
        end
      end
      default: ;
    endcase
  end

  // Page fields are reported for reads and writes that land in RAM in use.
  always_comb begin
    r_pv = ((kind_q == KIND_READ) || (kind_q == KIND_WRITE)) && dec_q.in_ram;
    if (!r_pv) begin
      r_pg = '0;
    end else if (kind_q == KIND_WRITE) begin
      r_pg = page_gen_new;
    end else begin
      r_pg = page_rdata_q;
    end
  end

  assign gen_next = gen_inc ? gen_bump(gen_q) : gen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q  <= GenW'(1);
      tick_q <= '0;
      irq_q  <= '0;
    end else begin
      gen_q <= gen_next;
      if (tick_add) begin
        tick_q <= tick_q + {{(TickW - TickInW){1'b0}}, ticks_q};
      end
      if (irq_upd) begin
        irq_q <= irq_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      out_data_q <= {5'd0, gen_next, r_pg, r_pv, r_sb, r_sv, r_rd, r_ok};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// ===== bench/bdpwt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the bus decoder: mirrors the machine state, predicts each result and compares.

module bdpwt_checker
  import bdpwt_pkg::*;
#(
  parameter int unsigned RAM_DEPTH  = RamBytesDef,
  parameter int unsigned ROM_DEPTH  = RomBytesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_ready_i,
  input  logic [InDataW-1:0]  req_data_i,
  input  logic [KindW-1:0]    req_kind_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  logic [OutDataW-1:0] rsp_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         outstanding_o,
  output int unsigned         fail_count_o
);

  localparam int unsigned PageCount = (RAM_DEPTH + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int unsigned RamAw     = $clog2(RAM_DEPTH);
  localparam int unsigned RomAw     = $clog2(ROM_DEPTH);
  localparam int unsigned PageAw    = (PageCount > 1) ? $clog2(PageCount) : 1;

  typedef struct {
    logic            ok;
    logic [ByteW-1:0] read_data;
    logic            serial_valid;
    logic [ByteW-1:0] serial_byte;
    logic            page_valid;
    logic [GenW-1:0] page_gen;
    logic [GenW-1:0] global_gen;
  } bus_result_t;

  // Mirror of the machine state and of the address map.
  logic [ByteW-1:0]    ram_mirror [RAM_DEPTH];
  logic [ByteW-1:0]    rom_mirror [ROM_DEPTH];
  logic [GenW-1:0]     page_gens  [PageCount];
  logic [GenW-1:0]     write_gen;
  logic [TickW-1:0]    tick_total;
  logic [IrqW-1:0]     irq_flags;
  logic [RamSizeW-1:0] map_ram_len;
  logic [AddrW-1:0]    map_ram_start;
  logic [AddrW-1:0]    map_rom_start;
  logic [AddrW-1:0]    map_serial_base;
  logic [AddrW-1:0]    map_timer_base;
  logic [AddrW-1:0]    map_irq_base;

  bus_result_t expected_results [$];

  function automatic logic in_window(logic [AddrW-1:0] a, logic [AddrW-1:0] base,
                                     logic [63:0] span);
    return ({32'd0, a} >= {32'd0, base}) && ({32'd0, a} < {32'd0, base} + span);
  endfunction

  // Generations count up and skip zero when they wrap.
  function automatic logic [GenW-1:0] next_gen(logic [GenW-1:0] g);
    return (g == '1) ? GenW'(1) : g + GenW'(1);
  endfunction

  // Applies one bus event to the mirror and returns the result it must give.
  function automatic bus_result_t predict_bus_event(logic [KindW-1:0] kind,
                                                    logic [AddrW-1:0] addr,
                                                    logic [ByteW-1:0] data,
                                                    logic [LineW-1:0] line,
                                                    logic [TickInW-1:0] ticks);
    bus_result_t r;
    logic [63:0] span;
    logic        hit_ram;
    logic [AddrW-1:0] off;
    logic [AddrW-1:0] rom_off;
    int unsigned page;
    r = '{default: '0};
    span = (map_ram_len > RAM_DEPTH) ? 64'(RAM_DEPTH) : 64'(map_ram_len);
    hit_ram = in_window(addr, map_ram_start, span);
    off = addr - map_ram_start;
    rom_off = addr - map_rom_start;
    page = off / PAGE_BYTES;
    case (kind)
      KIND_READ: begin
        r.ok = 1'b1;
        if (hit_ram) r.read_data = ram_mirror[off[RamAw-1:0]];
        else if (in_window(addr, map_rom_start, 64'(ROM_DEPTH)))
          r.read_data = rom_mirror[rom_off[RomAw-1:0]];
        else if (addr == map_serial_base) r.read_data = '0;
        else if (addr == map_serial_base + PairOffset) r.read_data = SerialReady;
        else if (addr == map_timer_base) r.read_data = tick_total[ByteW-1:0];
        else if (addr == map_irq_base) r.read_data = irq_flags[ByteW-1:0];
        else r.ok = 1'b0;
      end
      KIND_WRITE: begin
        if (hit_ram) begin
          ram_mirror[off[RamAw-1:0]] = data;
          write_gen = next_gen(write_gen);
          if (page < PageCount) page_gens[PageAw'(page)] = next_gen(page_gens[PageAw'(page)]);
          r.ok = 1'b1;
        end else if (in_window(addr, map_rom_start, 64'(ROM_DEPTH))) begin
          r.ok = 1'b0;
        end else if (addr == map_serial_base) begin
          r.serial_valid = 1'b1;
          r.serial_byte  = data;
          r.ok           = 1'b1;
        end else if (addr == map_irq_base + PairOffset) begin
          irq_flags = irq_flags & ~{24'd0, data};
          r.ok = 1'b1;
        end
      end
      KIND_IRQ_RAISE, KIND_IRQ_CLEAR: begin
        if (line < LineW'(IrqW)) begin
          if (kind == KIND_IRQ_RAISE) irq_flags = irq_flags | (IrqW'(1) << line[4:0]);
          else irq_flags = irq_flags & ~(IrqW'(1) << line[4:0]);
          r.ok = 1'b1;
        end
      end
      KIND_TICK: begin
        tick_total = tick_total + {32'd0, ticks};
        r.ok = 1'b1;
      end
      KIND_ROM_LOAD: begin
        if (addr < ROM_DEPTH) begin
          rom_mirror[addr[RomAw-1:0]] = data;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    if ((kind == KIND_READ || kind == KIND_WRITE) && hit_ram && page < PageCount) begin
      r.page_valid = 1'b1;
      r.page_gen   = page_gens[PageAw'(page)];
    end
    r.global_gen = write_gen;
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, expected, actual);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_result_t due;
    if (!rst_ni) begin
      foreach (ram_mirror[i]) ram_mirror[i] = '0;
      foreach (rom_mirror[i]) rom_mirror[i] = '0;
      foreach (page_gens[i]) page_gens[i] = '0;
      write_gen       = GenW'(1);
      tick_total      = '0;
      irq_flags       = '0;
      map_ram_len     = RamSizeRst;
      map_ram_start   = RamBaseRst;
      map_rom_start   = RomBaseRst;
      map_serial_base = SerialBaseRst;
      map_timer_base  = TimerBaseRst;
      map_irq_base    = IrqBaseRst;
      expected_results.delete();
      fail_count_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAM_SIZE:    map_ram_len     = cfg_data_i[RamSizeW-1:0];
          CFG_RAM_BASE:    map_ram_start   = cfg_data_i;
          CFG_ROM_BASE:    map_rom_start   = cfg_data_i;
          CFG_SERIAL_BASE: map_serial_base = cfg_data_i;
          CFG_TIMER_BASE:  map_timer_base  = cfg_data_i;
          CFG_IRQ_BASE:    map_irq_base    = cfg_data_i;
          default: ;
        endcase
      end
      // Results are checked before the request of this edge is predicted, so a
      // stray result can never be matched against a request just taken.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result 0x%0h arrived with no request outstanding", rsp_data_i);
          fail_count_o++;
        end else begin
          due = expected_results.pop_front();
          compare_field("ok", 32'(due.ok), 32'(rsp_data_i[0]));
          compare_field("read_data", 32'(due.read_data), 32'(rsp_data_i[8:1]));
          compare_field("serial_valid", 32'(due.serial_valid), 32'(rsp_data_i[9]));
          compare_field("serial_byte", 32'(due.serial_byte), 32'(rsp_data_i[17:10]));
          compare_field("page_valid", 32'(due.page_valid), 32'(rsp_data_i[18]));
          compare_field("page_generation", due.page_gen, rsp_data_i[50:19]);
          compare_field("global_generation", due.global_gen, rsp_data_i[82:51]);
        end
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(predict_bus_event(req_kind_i, req_data_i[31:0],
                                                     req_data_i[39:32], req_data_i[45:40],
                                                     req_data_i[77:46]));
    end
    outstanding_o = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the bus decoder testbench: clock, reset, request and register stimulus, verdict.

module tb_top;
  import bdpwt_pkg::*;

  // Sizes of the block under test; the checker is built with the same values.
  localparam int unsigned RamBytes  = RamBytesDef;
  localparam int unsigned RomBytes  = RomBytesDef;
  localparam int unsigned PageBytes = PageBytesDef;

  // Kinds that the block must ignore.
  localparam logic [KindW-1:0] KindSpareLo = 3'd6;
  localparam logic [KindW-1:0] KindSpareHi = 3'd7;

  // The limit covers the clearing pass after reset and every request, plus
  // whatever stalls the two sides add, with margin for the slowest plausible run.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ItemsPerMap  = 100;
  localparam int unsigned MapCount     = 7;

  // One complete address map as held in the configuration registers.
  typedef struct {
    logic [RamSizeW-1:0] ram_len;
    logic [AddrW-1:0]    ram_start;
    logic [AddrW-1:0]    rom_start;
    logic [AddrW-1:0]    serial_base;
    logic [AddrW-1:0]    timer_base;
    logic [AddrW-1:0]    irq_base;
  } bus_map_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_tvalid      = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata       = '0;
  logic [KindW-1:0]    s_tuser       = '0;
  logic                m_tvalid;
  logic                m_tready      = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx       = CFG_RAM_SIZE;
  logic [CfgDataW-1:0] cfg_data      = '0;

  int unsigned outstanding;
  int unsigned fail_count;

  // Percentages of cycles in which the sender holds back a request and the
  // receiver withholds tready.
  int unsigned send_gap_pct = 6;
  int unsigned recv_gap_pct = 56;

  bus_map_t bus_map;
  bus_map_t map_plan [MapCount];

  bus_decoder_with_page_write_tracking #(
    .RAM_DEPTH (RamBytes),
    .ROM_DEPTH (RomBytes),
    .PAGE_BYTES(PageBytes)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  bdpwt_checker #(
    .RAM_DEPTH (RamBytes),
    .ROM_DEPTH (RomBytes),
    .PAGE_BYTES(PageBytes)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_tvalid),
    .req_ready_i  (s_tready),
    .req_data_i   (s_tdata),
    .req_kind_i   (s_tuser),
    .rsp_valid_i  (m_tvalid),
    .rsp_ready_i  (m_tready),
    .rsp_data_i   (m_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A run that hangs on a handshake is stopped here.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // The receiver draws its readiness afresh at every falling edge.
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  // Offers one request and returns at the falling edge after it was taken.
  // tvalid is only lowered when a gap is drawn, so a back-to-back request
  // keeps it high without a second assignment in the same time step.
  task automatic push_request(input logic [KindW-1:0] kind, input logic [AddrW-1:0] addr,
                              input logic [ByteW-1:0] data, input logic [LineW-1:0] line,
                              input logic [TickInW-1:0] ticks);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, ticks, line, data, addr};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Holds back the sender until every outstanding result has come, then lets
  // the pipeline settle before anything else happens.
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
  endtask

  // Writes every register of the map; only called while the block is idle.
  task automatic load_map(input bus_map_t m);
    bus_map = m;
    write_reg(CFG_RAM_SIZE, CfgDataW'(m.ram_len));
    write_reg(CFG_RAM_BASE, m.ram_start);
    write_reg(CFG_ROM_BASE, m.rom_start);
    write_reg(CFG_SERIAL_BASE, m.serial_base);
    write_reg(CFG_TIMER_BASE, m.timer_base);
    write_reg(CFG_IRQ_BASE, m.irq_base);
    cfg_we <= 1'b0;
  endtask

  // Draws one request aimed at the current map. Fields that the kind does not
  // use still carry random values, so every bit of the request fields toggles.
  task automatic send_random_request();
    logic [KindW-1:0]   kind;
    logic [AddrW-1:0]   addr;
    logic [ByteW-1:0]   data;
    logic [LineW-1:0]   line;
    logic [TickInW-1:0] ticks;
    int unsigned roll;
    int unsigned used;
    int unsigned offset;
    roll  = $urandom_range(0, 99);
    addr  = $urandom;
    data  = ByteW'($urandom);
    line  = LineW'($urandom);
    ticks = $urandom;
    if (roll < 34) kind = KIND_READ;
    else if (roll < 64) kind = KIND_WRITE;
    else if (roll < 72) kind = KIND_IRQ_RAISE;
    else if (roll < 78) kind = KIND_IRQ_CLEAR;
    else if (roll < 85) kind = KIND_TICK;
    else if (roll < 95) kind = KIND_ROM_LOAD;
    else kind = $urandom_range(0, 1) ? KindSpareHi : KindSpareLo;

    used = (bus_map.ram_len > RamBytes) ? RamBytes : bus_map.ram_len;
    if (kind == KIND_READ || kind == KIND_WRITE) begin
      roll = $urandom_range(0, 99);
      if (roll < 40 && used != 0) begin
        // Half of these RAM accesses fall on the first bytes of some page, so
        // reads meet earlier writes and page generations climb.
        if ($urandom_range(0, 1)) begin
          offset = $urandom_range(0, (used - 1) / PageBytes) * PageBytes
                   + $urandom_range(0, 15);
          if (offset >= used) offset = used - 1;
        end else begin
          offset = $urandom_range(0, used - 1);
        end
        addr = bus_map.ram_start + offset;
      end else if (roll < 60) begin
        addr = bus_map.rom_start + ($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, RomBytes - 1));
      end else if (roll < 75) begin
        case ($urandom_range(0, 4))
          0: addr = bus_map.serial_base;
          1: addr = bus_map.serial_base + PairOffset;
          2: addr = bus_map.timer_base;
          3: addr = bus_map.irq_base;
          default: addr = bus_map.irq_base + PairOffset;
        endcase
      end else if (roll < 87) begin
        // Addresses at the edges of the RAM and ROM windows.
        case ($urandom_range(0, 5))
          0: addr = bus_map.ram_start - 1;
          1: addr = bus_map.ram_start + used;
          2: addr = bus_map.ram_start + used - 1;
          3: addr = bus_map.rom_start - 1;
          4: addr = bus_map.rom_start + RomBytes;
          default: addr = bus_map.rom_start + RomBytes - 1;
        endcase
      end
    end else if (kind == KIND_ROM_LOAD) begin
      // Mostly offsets inside the ROM, often the few that reads aim at.
      if ($urandom_range(0, 4) != 0)
        addr = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, RomBytes - 1);
    end else if (kind == KIND_IRQ_RAISE || kind == KIND_IRQ_CLEAR) begin
      // Lines 0 to 7 are the ones a pending read can show.
      roll = $urandom_range(0, 9);
      if (roll < 5) line = LineW'($urandom_range(0, 7));
      else if (roll < 8) line = LineW'($urandom_range(8, 31));
      else line = LineW'($urandom_range(32, 63));
    end else if (kind == KIND_TICK && $urandom_range(0, 1)) begin
      ticks = $urandom_range(0, 300);
    end
    push_request(kind, addr, data, line, ticks);
  endtask

  // A block of random requests with one full hold-off half way through.
  task automatic run_random_block(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_results_done();
      send_random_request();
    end
  endtask

  initial begin
    // The reset map, written explicitly so that every register sees a write.
    map_plan[0] = '{RamSizeRst, RamBaseRst, RomBaseRst, SerialBaseRst, TimerBaseRst,
                    IrqBaseRst};
    // Size above the RAM (acts as full RAM) placed at the very top of the
    // address space; serial and irq registers are shadowed by RAM and ROM,
    // and the serial status address wraps to zero.
    map_plan[1] = '{17'h1FFFF, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFC,
                    32'h0001_0000, 32'hFFFF_FFFE};
    // No RAM at all; the ROM window runs off the top of the address space
    // and the serial status address shadows the timer.
    map_plan[2] = '{17'd0, 32'h0000_1000, 32'hFFFF_8000, 32'h0000_0100,
                    32'h0000_0104, 32'h0000_0200};
    // A single byte of RAM.
    map_plan[3] = '{17'd1, 32'h1234_5678, 32'h2000_0000, 32'h3000_0000,
                    32'h4000_0000, 32'h5000_0000};
    // One page plus a byte, with the ROM starting on the last RAM byte.
    map_plan[4] = '{17'd4097, 32'h0080_0000, 32'h0080_1000, 32'h0090_0000,
                    32'h0090_0008, 32'h0090_0010};
    // Full RAM directly above the ROM; the irq clear register wraps to zero.
    map_plan[5] = '{17'd65536, 32'h8000_0000, 32'h7FFF_0000, 32'hC000_0000,
                    32'hC000_0010, 32'hFFFF_FFFC};
    map_plan[6] = '{RamSizeW'($urandom_range(1, 131071)), $urandom, $urandom, $urandom,
                    $urandom, $urandom};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // The block is still clearing its memories here, so it is idle.
    load_map(map_plan[0]);

    // Directed requests on the reset map; the first one also waits out the
    // clearing pass.
    push_request(KIND_READ, 32'h0000_0000, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, 32'h0000_0000, 8'hFF, 6'd0, 32'd0);
    push_request(KIND_READ, 32'h0000_0000, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, 32'h0000_FFFF, 8'h00, 6'd0, 32'd0);
    push_request(KIND_READ, 32'h0001_0000, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, 32'h0001_0000, 8'h3C, 6'd0, 32'd0);
    push_request(KIND_ROM_LOAD, 32'h0000_0000, 8'hA5, 6'd0, 32'd0);
    push_request(KIND_ROM_LOAD, 32'h0000_FFFF, 8'h5A, 6'd0, 32'd0);
    push_request(KIND_ROM_LOAD, 32'h0001_0000, 8'hC3, 6'd0, 32'd0);
    push_request(KIND_READ, RomBaseRst, 8'h00, 6'd0, 32'd0);
    push_request(KIND_READ, RomBaseRst + 32'h0000_FFFF, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, RomBaseRst, 8'h11, 6'd0, 32'd0);
    push_request(KIND_WRITE, SerialBaseRst, 8'h41, 6'd0, 32'd0);
    push_request(KIND_READ, SerialBaseRst + PairOffset, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, SerialBaseRst + PairOffset, 8'h42, 6'd0, 32'd0);
    // Two ticks that carry the counter past 32 bits.
    push_request(KIND_TICK, 32'h0000_0000, 8'h00, 6'd0, 32'hFFFF_FFFF);
    push_request(KIND_TICK, 32'h0000_0000, 8'h00, 6'd0, 32'd2);
    push_request(KIND_READ, TimerBaseRst, 8'h00, 6'd0, 32'd0);
    push_request(KIND_IRQ_RAISE, 32'h0000_0000, 8'h00, 6'd0, 32'd0);
    push_request(KIND_IRQ_RAISE, 32'h0000_0000, 8'h00, 6'd31, 32'd0);
    push_request(KIND_IRQ_RAISE, 32'h0000_0000, 8'h00, 6'd63, 32'd0);
    push_request(KIND_READ, IrqBaseRst, 8'h00, 6'd0, 32'd0);
    push_request(KIND_WRITE, IrqBaseRst + PairOffset, 8'hFF, 6'd0, 32'd0);
    push_request(KIND_READ, IrqBaseRst + PairOffset, 8'h00, 6'd0, 32'd0);
    push_request(KIND_IRQ_CLEAR, 32'h0000_0000, 8'h00, 6'd31, 32'd0);
    push_request(KindSpareHi, 32'h0000_0000, 8'h00, 6'd0, 32'd0);

    // Random requests, one block per map. The first two maps run with a busy
    // sender and a slow receiver, the next two the other way round, and the
    // rest with neither side idling.
    for (int unsigned p = 0; p < MapCount; p++) begin
      if (p > 0) begin
        wait_results_done();
        load_map(map_plan[p]);
      end
      if (p < 2) begin
        send_gap_pct = 6;
        recv_gap_pct = 56;
      end else if (p < 4) begin
        send_gap_pct = 56;
        recv_gap_pct = 6;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      run_random_block(ItemsPerMap);
    end

    // Let every result arrive, then leave room for any stray one to show.
    wait_results_done();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
